### rtl/c_escape_unescaper_utf8_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape unescaper
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_UNESCAPER_UTF8_UNIT_DEFINES_SVH
`define C_ESCAPE_UNESCAPER_UTF8_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CESU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CESU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define CESU_ASSERT(lbl, prop, msg)
`define CESU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/cesu_pkg.sv
// ----------------------------------------------------------------------------
// cesu_pkg
// Types, codes and helper functions shared by the escape unescaper.
// ----------------------------------------------------------------------------
package cesu_pkg;

  localparam int unsigned CesuQDepth  = 4;
  localparam int unsigned CmdMaxBytes = 5;

  localparam logic [20:0] CpMax     = 21'h10FFFF;
  localparam logic [20:0] SurrLo    = 21'h00D800;
  localparam logic [20:0] SurrHi    = 21'h00DFFF;
  localparam logic [20:0] ByteMax   = 21'h0000FF;

  typedef enum logic [7:0] {
    MdNormal = 8'b0000_0001,
    MdEsc    = 8'b0000_0010,
    MdOct    = 8'b0000_0100,
    MdHexF   = 8'b0000_1000,
    MdHex    = 8'b0001_0000,
    MdU4     = 8'b0010_0000,
    MdU8     = 8'b0100_0000,
    MdU8Bad  = 8'b1000_0000
  } mode_e;

  typedef enum logic [3:0] {
    StOk         = 4'd0,
    StTrailBs    = 4'd1,
    StOctRange   = 4'd2,
    StHexNoDigit = 4'd3,
    StHexRange   = 4'd4,
    StUBad       = 4'd5,
    StUSurr      = 4'd6,
    StBigUBad    = 4'd7,
    StBigURange  = 4'd8,
    StBigUSurr   = 4'd9,
    StUnknownEsc = 4'd10
  } status_e;

  typedef struct packed {
    logic [CmdMaxBytes-1:0][7:0] bytes;
    logic [2:0]                  len;
    status_e                     status;
    logic                        last;
  } cmd_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic utf8_t utf8_enc(logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp <= 21'h7F) begin
      u.b[0] = cp[7:0];
      u.n    = 3'd1;
    end else if (cp <= 21'h7FF) begin
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
      u.n    = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
      u.n    = 3'd3;
    end else begin
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
      u.n    = 3'd4;
    end
    return u;
  endfunction

endpackage

### rtl/cesu_in_if.sv
// ----------------------------------------------------------------------------
// cesu_in_if
// Source character channel: one escaped character per request.
// ----------------------------------------------------------------------------
interface cesu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       char_valid;
  logic       in_last;

  modport source (output valid, in_char, char_valid, in_last, input ready);
  modport sink   (input valid, in_char, char_valid, in_last, output ready);
endinterface

### rtl/cesu_out_if.sv
// ----------------------------------------------------------------------------
// cesu_out_if
// Result channel: one unescaped byte or error code per request.
// ----------------------------------------------------------------------------
interface cesu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [3:0] status;

  modport source (output valid, out_byte, out_last, status, input ready);
  modport sink   (input valid, out_byte, out_last, status, output ready);
endinterface

### rtl/cesu_front.sv
// ----------------------------------------------------------------------------
// cesu_front
// Escape parser: takes one character per cycle while the command queue has room and emits a byte burst command.
// ----------------------------------------------------------------------------
module cesu_front
  import cesu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  cesu_in_if.sink      in_i,
  input  logic         q_ready_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  mode_e       mode_q, mode_d;
  logic [20:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        swallow_q, swallow_d;
  logic        term_q;
  logic        accept;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && q_ready_i;

  always_comb begin
    logic [7:0]      c;
    logic [3:0]      hv;
    logic [24:0]     nxt;
    logic            norm;
    logic [2:0]      nb;
    logic [4:0][7:0] byt;
    status_e         err;
    utf8_t           u;
    logic            lst;

    c    = in_i.in_char;
    hv   = hex_val(c);
    nxt  = {acc_q, 4'h0} + 25'(hv);
    norm = 1'b0;
    nb   = '0;
    byt  = '0;
    err  = StOk;
    u    = utf8_enc(acc_q);
    lst  = 1'b0;
    mode_d    = mode_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    swallow_d = swallow_q;

    if (swallow_q) begin
      if (in_i.in_last) begin
        swallow_d = 1'b0;
        mode_d    = MdNormal;
        acc_d     = '0;
        cnt_d     = '0;
      end
    end else begin
      if (in_i.char_valid) begin
        case (mode_q)
          MdEsc: begin
            mode_d = MdNormal;
            case (c)
              "a": begin byt[0] = 8'd7;  nb = 3'd1; end
              "b": begin byt[0] = 8'd8;  nb = 3'd1; end
              "f": begin byt[0] = 8'd12; nb = 3'd1; end
              "n": begin byt[0] = 8'd10; nb = 3'd1; end
              "r": begin byt[0] = 8'd13; nb = 3'd1; end
              "t": begin byt[0] = 8'd9;  nb = 3'd1; end
              "v": begin byt[0] = 8'd11; nb = 3'd1; end
              "\\", "?", "'", "\"": begin byt[0] = c; nb = 3'd1; end
              "x", "X": begin mode_d = MdHexF; acc_d = '0; end
              "u": begin mode_d = MdU4; acc_d = '0; cnt_d = '0; end
              "U": begin mode_d = MdU8; acc_d = '0; cnt_d = '0; end
              default: begin
                if (is_oct(c)) begin
                  mode_d = MdOct;
                  acc_d  = 21'(c[2:0]);
                  cnt_d  = 4'd1;
                end else begin
                  err = StUnknownEsc;
                end
              end
            endcase
          end
          MdOct: begin
            if (is_oct(c)) begin
              acc_d = {acc_q[17:0], c[2:0]};
              cnt_d = cnt_q + 4'd1;
              if (cnt_d >= 4'd3) begin
                if (acc_d > ByteMax) begin
                  err = StOctRange;
                end else begin
                  byt[0] = acc_d[7:0];
                  nb     = 3'd1;
                  mode_d = MdNormal;
                  acc_d  = '0;
                  cnt_d  = '0;
                end
              end
            end else begin
              byt[0] = acc_q[7:0];
              nb     = 3'd1;
              mode_d = MdNormal;
              acc_d  = '0;
              cnt_d  = '0;
              norm   = 1'b1;
            end
          end
          MdHexF: begin
            if (!is_hex(c)) begin
              err = StHexNoDigit;
            end else begin
              acc_d  = 21'(hv);
              mode_d = MdHex;
            end
          end
          MdHex: begin
            if (is_hex(c)) begin
              acc_d = {acc_q[16:0], hv};
              if (acc_d > ByteMax) err = StHexRange;
            end else begin
              byt[0] = acc_q[7:0];
              nb     = 3'd1;
              mode_d = MdNormal;
              acc_d  = '0;
              cnt_d  = '0;
              norm   = 1'b1;
            end
          end
          MdU4: begin
            if (!is_hex(c)) begin
              err = StUBad;
            end else begin
              acc_d = {5'b0, acc_q[11:0], hv};
              cnt_d = cnt_q + 4'd1;
              if (cnt_d >= 4'd4) begin
                if (acc_d >= SurrLo && acc_d <= SurrHi) begin
                  err = StUSurr;
                end else begin
                  u      = utf8_enc(acc_d);
                  byt[3:0] = u.b;
                  nb     = u.n;
                  mode_d = MdNormal;
                  acc_d  = '0;
                  cnt_d  = '0;
                end
              end
            end
          end
          MdU8, MdU8Bad: begin
            cnt_d = cnt_q + 4'd1;
            if (mode_q == MdU8) begin
              if (is_hex(c)) begin
                if (nxt > 25'(CpMax)) begin
                  mode_d = MdU8Bad;
                  acc_d  = 21'(StBigURange);
                end else begin
                  acc_d = nxt[20:0];
                end
              end else begin
                mode_d = MdU8Bad;
                acc_d  = 21'(StBigUBad);
              end
            end
            if (cnt_d >= 4'd8) begin
              if (mode_d == MdU8Bad) begin
                err = status_e'(acc_d[3:0]);
              end else if (acc_d >= SurrLo && acc_d <= SurrHi) begin
                err = StBigUSurr;
              end else begin
                u      = utf8_enc(acc_d);
                byt[3:0] = u.b;
                nb     = u.n;
                mode_d = MdNormal;
                acc_d  = '0;
                cnt_d  = '0;
              end
            end
          end
          default: norm = 1'b1;
        endcase
        if (norm) begin
          if (c == "\\") begin
            mode_d = MdEsc;
          end else begin
            byt[nb] = c;
            nb      = nb + 3'd1;
          end
        end
      end

      if (err == StOk && in_i.in_last) begin
        case (mode_d)
          MdEsc:          err = StTrailBs;
          MdOct, MdHex: begin
            byt[nb] = acc_d[7:0];
            nb      = nb + 3'd1;
          end
          MdHexF:         err = StHexNoDigit;
          MdU4:           err = StUBad;
          MdU8, MdU8Bad:  err = StBigUBad;
          default:        ;
        endcase
      end

      if (err != StOk) begin
        byt[nb]   = 8'h00;
        nb        = nb + 3'd1;
        lst       = 1'b1;
        mode_d    = MdNormal;
        acc_d     = '0;
        cnt_d     = '0;
        swallow_d = !in_i.in_last;
      end else if (in_i.in_last) begin
        mode_d = MdNormal;
        acc_d  = '0;
        cnt_d  = '0;
        if (term_q) begin
          byt[nb] = 8'h00;
          nb      = nb + 3'd1;
        end
        lst = 1'b1;
      end
    end

    cmd_o.bytes  = byt;
    cmd_o.len    = nb;
    cmd_o.status = err;
    cmd_o.last   = lst;
  end

  assign push_o = accept && (cmd_o.len != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MdNormal;
      acc_q     <= '0;
      cnt_q     <= '0;
      swallow_q <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      swallow_q <= swallow_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= 1'b1;
    end else if (cfg_we_i) begin
      term_q <= cfg_wdata_i;
    end
  end

endmodule

### rtl/cesu_queue.sv
// ----------------------------------------------------------------------------
// cesu_queue
// Short command FIFO between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module cesu_queue
  import cesu_pkg::*;
#(
  parameter int unsigned Depth = CesuQDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign ready_o = cnt_q != Full;
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + PtrW'(1);
      if (pop_i)  rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/cesu_back.sv
// ----------------------------------------------------------------------------
// cesu_back
// Byte emitter: walks the head command one byte per cycle, while out_o is not stalled, into an output register.
// ----------------------------------------------------------------------------
module cesu_back
  import cesu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  cesu_out_if.source out_o
);

  logic [2:0] idx_q;
  logic       ovalid_q;
  logic [7:0] byte_q;
  logic       last_q;
  status_e    status_q;
  logic       advance;
  logic       final_byte;

  assign advance    = valid_i && (!ovalid_q || out_o.ready);
  assign final_byte = idx_q == (head_i.len - 3'd1);
  assign pop_o      = advance && final_byte;

  assign out_o.valid    = ovalid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.out_last = last_q;
  assign out_o.status   = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (advance) begin
        ovalid_q <= 1'b1;
        idx_q    <= final_byte ? '0 : idx_q + 3'd1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q   <= head_i.bytes[idx_q];
      last_q   <= final_byte && head_i.last;
      status_q <= final_byte ? head_i.status : StOk;
    end
  end

endmodule

### rtl/c_escape_unescaper_utf8_unit.sv
// ----------------------------------------------------------------------------
// c_escape_unescaper_utf8_unit
// Streaming C string unescaper with UTF-8 output and error reporting.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                          Handshake
// in_i      in   in_char, char_valid, in_last     valid/ready
// out_o     out  out_byte, out_last, status       valid/ready
// cfg       in   cfg_wdata_i (append_terminator)  cfg_we_i, no wait
//
// Each character is parsed in the cycle it is accepted; one input per cycle.
// Results leave one byte per cycle from the output register while out_o is not
// stalled; an item gives up to 5 bytes (UTF-8 plus terminator).
// Input stalls only when the command queue (QDepth entries) is full.
// Reset: parser back to plain text, queue empty, append_terminator set.
// ----------------------------------------------------------------------------
`include "c_escape_unescaper_utf8_unit_defines.svh"

module c_escape_unescaper_utf8_unit
  import cesu_pkg::*;
#(
  parameter int unsigned QDepth = CesuQDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  cesu_in_if.sink    in_i,
  cesu_out_if.source out_o
);

  logic push;
  logic q_ready;
  logic q_valid;
  logic pop;
  cmd_t cmd;
  cmd_t head;

  cesu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  cesu_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  cesu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  `CESU_ASSERT(a_push_room, push |-> q_ready, "command pushed into full queue")
  `CESU_ASSERT(a_cmd_len, push |-> (cmd.len != 3'd0 && cmd.len <= 3'(CmdMaxBytes)), "bad cmd length")
  `CESU_ASSERT(a_pop_valid, pop |-> q_valid, "pop from empty queue")
  `CESU_ASSERT(a_err_last, (out_o.valid && out_o.status != StOk) |-> (out_o.out_last && out_o.out_byte == 8'h00), "error result not final")
  `CESU_ASSERT_NEXT(a_push_fill, (push && !pop), q_valid, "queue empty after push")

endmodule
